>>> hw/rtl/glr_pkg.sv
`default_nettype none

package glr_pkg;

    localparam int RECIP_BITS     = 17;
    localparam int FRAC_BITS      = 16;
    localparam int FRAC_ONE       = 65536;
    localparam int ROUND_HALF     = 32768;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GLIDE_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GLIDE_RECIP   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IGNORE_ZEROES = 2'd2;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_CHANGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAC,
        ST_INTERP,
        ST_DONE
    } glr_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/linear_glide_ramp_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  kind, value
// out       output     out_valid/out_stall  sample_value
// cfg       input      cfg_write            cfg_index, cfg_data
//
// A change transaction is only held as pending.
// A tick with a running glide passes through accept, fraction multiply,
// interpolation multiply and write-back, both multiplies through the one shared multiplier.
// A tick with no running glide goes from accept straight to write-back.
// Reset clears the current, start and end values and the count, sets the length to one and the
// reciprocal to 1.0. A stalled output holds the block in write-back.

module linear_glide_ramp_top #(
    parameter int VALUE_BITS = 24,
    parameter int COUNT_BITS = 16,
    localparam int CFG_BITS  = (COUNT_BITS > glr_pkg::RECIP_BITS) ?
                               COUNT_BITS : glr_pkg::RECIP_BITS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                kind,
    input  wire  signed [VALUE_BITS-1:0]       value,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic signed [VALUE_BITS-1:0]       sample_value,
    input  wire                                cfg_write,
    input  wire  [glr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire  [CFG_BITS-1:0]                cfg_data
);

    import glr_pkg::*;

    localparam int AW = (VALUE_BITS > COUNT_BITS) ? VALUE_BITS + 1 : COUNT_BITS + 1;
    localparam int BW = RECIP_BITS + 1;
    localparam int PW = AW + BW;
    localparam logic signed [PW-1:0] FRAC_ONE_P   = PW'(FRAC_ONE);
    localparam logic signed [PW-1:0] ROUND_HALF_P = PW'(ROUND_HALF);

    glr_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]        samples_reg;
    logic [RECIP_BITS-1:0]        recip_reg;
    logic                         ignore_reg;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic signed [VALUE_BITS-1:0] current_reg, current_next;
    logic signed [VALUE_BITS-1:0] start_reg, start_next;
    logic signed [VALUE_BITS-1:0] end_reg, end_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic signed [VALUE_BITS-1:0] pend_value_reg, pend_value_next;
    logic                         active_reg, active_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [VALUE_BITS-1:0] out_data_reg, out_data_next;

    logic [COUNT_BITS-1:0]        len;
    logic [COUNT_BITS-1:0]        num;
    logic [COUNT_BITS-1:0]        eff_count;
    logic                         accept;
    logic                         apply;
    logic                         mul_en;
    logic signed [AW-1:0]         mul_a;
    logic signed [BW-1:0]         mul_b;
    logic signed [PW-1:0]         product;
    logic [BW-1:0]                frac_x;
    logic signed [PW-1:0]         rounded;
    logic signed [VALUE_BITS-1:0] glided;
    logic signed [VALUE_BITS-1:0] result;

    glr_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign len = (samples_reg == '0) ? {{(COUNT_BITS-1){1'b0}}, 1'b1} : samples_reg;
    assign num = (count_reg > len) ? '0 : len - count_reg;
    assign frac_x = (product > FRAC_ONE_P) ? BW'(FRAC_ONE) : product[BW-1:0];
    assign rounded = (product + ROUND_HALF_P) >>> FRAC_BITS;
    assign glided = start_reg + rounded[VALUE_BITS-1:0];
    assign result = active_reg ? glided : current_reg;
    assign accept = in_valid && (state_reg == ST_IDLE);
    assign apply = pend_valid_reg && !(ignore_reg && (pend_value_reg == '0));
    assign eff_count = apply ? len : count_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sample_value = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        current_next    = current_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        active_next     = active_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_CHANGE)
                    begin
                        pend_valid_next = 1'b1;
                        pend_value_next = value;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        if (apply)
                        begin
                            start_next = current_reg;
                            end_next   = pend_value_reg;
                        end
                        if (eff_count != '0)
                        begin
                            count_next  = eff_count - 1'b1;
                            active_next = 1'b1;
                            state_next  = ST_FRAC;
                        end
                        else
                        begin
                            count_next  = eff_count;
                            active_next = 1'b0;
                            state_next  = ST_DONE;
                        end
                    end
                end
            end
            ST_FRAC:
            begin
                mul_en     = 1'b1;
                mul_a      = signed'({{(AW-COUNT_BITS){1'b0}}, num});
                mul_b      = signed'({1'b0, recip_reg});
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                mul_en     = 1'b1;
                mul_a      = AW'(end_reg) - AW'(start_reg);
                mul_b      = signed'(frac_x);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = result;
                    out_valid_next = 1'b1;
                    current_next   = result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg    <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
            recip_reg      <= RECIP_BITS'(FRAC_ONE);
            ignore_reg     <= 1'b0;
            count_reg      <= '0;
            current_reg    <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            pend_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GLIDE_SAMPLES: samples_reg <= cfg_data[COUNT_BITS-1:0];
                    REG_GLIDE_RECIP:   recip_reg   <= cfg_data[RECIP_BITS-1:0];
                    REG_IGNORE_ZEROES: ignore_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            count_reg      <= count_next;
            current_reg    <= current_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            pend_valid_reg <= pend_valid_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        out_data_reg   <= out_data_next;
    end

    a_change_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (kind == KIND_CHANGE)) |=> !in_stall)
        else $error("change transaction left the block busy");

    a_tick_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (kind == KIND_TICK)) |=> in_stall)
        else $error("tick transaction did not start the sequencer");

    a_result_from_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared outside write-back");

endmodule

`default_nettype wire

>>> hw/rtl/glr_mul.sv
`default_nettype none

module glr_mul #(
    parameter int AW = 25,
    parameter int BW = 18
) (
    input  wire                        clk,
    input  wire                        en,
    input  wire  signed [AW-1:0]       a,
    input  wire  signed [BW-1:0]       b,
    output logic signed [AW+BW-1:0]    product
);

    logic signed [AW+BW-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= a * b;
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

>>> sim/linear_glide_ramp_tb.sv
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import glr_pkg::*;

    localparam int VALUE_BITS = 24;
    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 17;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = 24'sh7FFFFF;
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = 24'sh800000;

    typedef struct {
        logic                         kind;
        logic signed [VALUE_BITS-1:0] value;
    } glide_event_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             kind = KIND_TICK;
    logic signed [VALUE_BITS-1:0]     value = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic signed [VALUE_BITS-1:0]     sample_value;
    logic                             cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0]        cfg_index = REG_GLIDE_SAMPLES;
    logic [CFG_BITS-1:0]              cfg_data = '0;

    glide_event_t                     glide_events[$];
    logic signed [VALUE_BITS-1:0]     expected_samples[$];

    // Shadow copy of the glide state and the registers.
    logic [COUNT_BITS-1:0]            glide_len = 16'd1;
    logic [CFG_BITS-1:0]              glide_step = 17'd65536;
    logic                             skip_zero = 1'b0;
    logic [COUNT_BITS-1:0]            steps_left = '0;
    logic signed [VALUE_BITS-1:0]     glide_now = '0;
    logic signed [VALUE_BITS-1:0]     glide_from = '0;
    logic signed [VALUE_BITS-1:0]     glide_to = '0;
    logic                             target_held = 1'b0;
    logic signed [VALUE_BITS-1:0]     held_target = '0;

    logic                             in_fire = 1'b0;
    int                               in_gap = 0;
    int                               out_hold = 0;
    bit                               in_calm = 1'b0;
    bit                               out_calm = 1'b0;
    int                               fail_count = 0;

    linear_glide_ramp_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void predict_glide(input logic ev_kind,
                                          input logic signed [VALUE_BITS-1:0] ev_value);
        logic [COUNT_BITS-1:0] len;
        longint                num;
        longint                frac;
        longint                from_v;
        longint                to_v;
        longint                prod;
        longint                delta;
        len = (glide_len == '0) ? 16'd1 : glide_len;
        if (ev_kind == KIND_CHANGE)
        begin
            held_target = ev_value;
            target_held = 1'b1;
            return;
        end
        if (target_held)
        begin
            if (!(skip_zero && held_target == '0))
            begin
                glide_from = glide_now;
                glide_to   = held_target;
                steps_left = len;
            end
            target_held = 1'b0;
        end
        if (steps_left != '0)
        begin
            steps_left = steps_left - 1'b1;
            num = (steps_left > len) ? 0 : longint'(len) - longint'(steps_left);
            frac = num * longint'(glide_step);
            if (frac > FRAC_ONE)
                frac = FRAC_ONE;
            from_v = longint'(glide_from);
            to_v   = longint'(glide_to);
            prod   = (to_v - from_v) * frac;
            delta  = (prod + ROUND_HALF) >>> FRAC_BITS;
            glide_now = VALUE_BITS'(from_v + delta);
        end
        expected_samples.push_back(glide_now);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return '0;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic push_change(input logic signed [VALUE_BITS-1:0] target);
        glide_events.push_back('{KIND_CHANGE, target});
    endtask

    task automatic push_tick();
        glide_events.push_back('{KIND_TICK, VALUE_BITS'($urandom)});
    endtask

    task automatic cfg_put(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
    endtask

    task automatic set_glide(input logic [COUNT_BITS-1:0] len,
                             input logic [CFG_BITS-1:0] step,
                             input logic skip);
        cfg_put(REG_GLIDE_SAMPLES, {1'($urandom_range(0, 1)), len});
        cfg_put(REG_GLIDE_RECIP, step);
        cfg_put(REG_IGNORE_ZEROES, {16'($urandom), skip});
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Waits until every transaction has gone in and every sample has come out,
    // then lets the block settle after a trailing change.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (glide_events.size() != 0 || in_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
        if (in_valid && !in_stall)
            predict_glide(kind, value);
        if (cfg_write)
        begin
            case (cfg_index)
                REG_GLIDE_SAMPLES: glide_len  = cfg_data[COUNT_BITS-1:0];
                REG_GLIDE_RECIP:   glide_step = cfg_data;
                REG_IGNORE_ZEROES: skip_zero  = cfg_data[0];
                default: ;
            endcase
        end
        if (out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, got %0d", $time, sample_value);
                fail_count++;
            end
            else
            begin
                if (sample_value !== expected_samples[0])
                begin
                    $display("%0t: sample_value expected %0d, got %0d",
                             $time, expected_samples[0], sample_value);
                    fail_count++;
                end
                void'(expected_samples.pop_front());
            end
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            out_hold = out_calm ? 0 : $urandom_range(0, 10);
        end
    end

    always @(negedge clk)
    begin
        glide_event_t ev;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (glide_events.size() != 0)
            begin
                ev = glide_events.pop_front();
                in_valid <= 1'b1;
                kind     <= ev.kind;
                value    <= ev.value;
                if ($urandom_range(0, 39) == 0)
                    in_calm = !in_calm;
                in_gap = in_calm ? 0 : $urandom_range(0, 10);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        int queued;
        int phase_items;
        int phase_size;
        int run_len;
        int eff;
        int len_pick;
        int step_pick;
        int r;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: length one, full step, zero targets taken.
        push_tick();
        push_change(VALUE_MAX);
        push_tick();
        push_change(VALUE_MIN);
        push_change(24'sd5);
        push_tick();
        push_change('0);
        push_tick();
        push_change(VALUE_MIN);
        push_tick();
        wait_idle();

        // Zero targets dropped, also when a real target came just before.
        cfg_put(REG_UNUSED, 17'h1FFFF);
        set_glide(16'd4, 17'd16384, 1'b1);
        push_change(VALUE_MAX);
        push_tick();
        push_change('0);
        push_tick();
        push_change(24'sd123456);
        push_change('0);
        push_tick();
        push_tick();
        wait_idle();

        // Longest glide with a zero step holds the start value.
        set_glide(16'hFFFF, 17'd0, 1'b0);
        push_change(VALUE_MIN);
        push_tick();
        push_tick();
        wait_idle();

        // Count left above the new length, then a fraction of exactly one.
        set_glide(16'd3, 17'd65536, 1'b0);
        push_tick();
        push_change(VALUE_MAX);
        push_tick();
        wait_idle();

        // Zero length behaves as one, with an oversized step.
        set_glide(16'd0, 17'h1FFFF, 1'b1);
        push_change(24'sd1000);
        push_tick();
        wait_idle();

        queued = 0;
        while (queued < 1750)
        begin
            r = $urandom_range(0, 19);
            len_pick = (r == 0) ? 0 :
                       (r == 1) ? 65535 :
                       (r == 2) ? $urandom_range(0, 65535) : $urandom_range(1, 16);
            eff = (len_pick == 0) ? 1 : len_pick;
            r = $urandom_range(0, 9);
            step_pick = (r == 0) ? 0 :
                        (r == 1) ? FRAC_ONE :
                        (r == 2) ? $urandom_range(0, 131071) : (FRAC_ONE + eff / 2) / eff;
            set_glide(COUNT_BITS'(len_pick), CFG_BITS'(step_pick), 1'($urandom_range(0, 1)));
            phase_size = $urandom_range(60, 110);
            phase_items = phase_size;
            while (phase_items > 0)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                begin
                    run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
                    repeat (run_len) push_change(pick_value());
                    phase_items -= run_len;
                    run_len = $urandom_range(1, (eff > 20) ? 40 : eff + 3);
                    repeat (run_len) push_tick();
                    phase_items -= run_len;
                end
                else if (r == 7)
                begin
                    run_len = $urandom_range(1, 8);
                    repeat (run_len)
                    begin
                        if ($urandom_range(0, 1) == 1)
                            push_change(pick_value());
                        else
                            push_tick();
                    end
                    phase_items -= run_len;
                end
                else
                begin
                    run_len = $urandom_range(1, 5);
                    repeat (run_len) push_tick();
                    phase_items -= run_len;
                end
            end
            queued += phase_size - phase_items;
            wait_idle();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> linear_glide_ramp_top.f
hw/rtl/glr_pkg.sv
hw/rtl/glr_mul.sv
hw/rtl/linear_glide_ramp_top.sv
sim/linear_glide_ramp_tb.sv
